// ===== rtl/rcf_pkg.sv =====
// Shared types and constants for the RTMP chunk framer.
package rcf_pkg;

    localparam int CHUNK_W   = 17;
    localparam int JOB_BYTES = 18;
    localparam int JOB_CNT_W = $clog2(JOB_BYTES + 1);

    localparam logic [CHUNK_W-1:0] MAX_CHUNK_BYTES = 17'd65536;
    localparam logic [CHUNK_W-1:0] CHUNK_RESET     = 17'd128;
    localparam logic [23:0]        TS_CAP          = 24'hFFFFFF;

    localparam logic OP_BEGIN   = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    localparam logic [1:0] FMT_FULL  = 2'd0;
    localparam logic [1:0] FMT_CONT  = 2'd3;

    // Bytes produced by one input transaction, byte 0 goes out first.
    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0] data;
        logic [JOB_CNT_W-1:0]      count;
        logic                      done;
    } job_t;

    typedef struct packed {
        logic busy;
        logic last;
        logic advance;
    } emit_status_t;

endpackage

// ===== rtl/rcf_build.sv =====
// Message state, chunk size register and per-transaction byte list builder.
module rcf_build
    import rcf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                chunk_len_we,
    input  logic [CHUNK_W-1:0]  chunk_len,
    input  logic                take,
    input  logic                opcode,
    input  logic [16:0]         stream_channel,
    input  logic [31:0]         msg_timestamp,
    input  logic [23:0]         msg_length,
    input  logic [7:0]          msg_type,
    input  logic [31:0]         msg_stream,
    input  logic [7:0]          payload_byte,
    output job_t                job
);

    typedef struct packed {
        logic [2:0][7:0] b;
        logic [1:0]      len;
    } basic_t;

    function automatic basic_t basic_hdr(input logic [1:0] fmt, input logic [16:0] cs);
        basic_t      r;
        logic [16:0] rel;
        rel = cs - 17'd64;
        r.b = '0;
        if (cs >= 17'd319)
        begin
            r.b[0] = {fmt, 6'd1};
            r.b[1] = rel[7:0];
            r.b[2] = rel[15:8];
            r.len  = 2'd3;
        end
        else if (cs >= 17'd64)
        begin
            r.b[0] = {fmt, 6'd0};
            r.b[1] = rel[7:0];
            r.len  = 2'd2;
        end
        else
        begin
            r.b[0] = {fmt, cs[5:0]};
            r.len  = 2'd1;
        end
        return r;
    endfunction

    // Basic header followed by up to 15 more bytes.
    function automatic logic [JOB_BYTES-1:0][7:0] place(input basic_t bh,
                                                        input logic [14:0][7:0] tail);
        logic [JOB_BYTES-1:0][7:0] d1, d2, d3;
        d1 = '0;
        d2 = '0;
        d3 = '0;
        for (int i = 0; i < 15; i++)
        begin
            d1[i+1] = tail[i];
            d2[i+2] = tail[i];
            d3[i+3] = tail[i];
        end
        d1[0] = bh.b[0];
        d2[0] = bh.b[0];
        d2[1] = bh.b[1];
        d3[2:0] = bh.b;
        if (bh.len == 2'd3)
            return d3;
        else if (bh.len == 2'd2)
            return d2;
        else
            return d1;
    endfunction

    logic [CHUNK_W-1:0] chunk_len_reg;
    logic [23:0]        remaining_reg, remaining_next;
    logic [CHUNK_W-1:0] in_chunk_reg, in_chunk_next;
    logic [16:0]        channel_reg, channel_next;
    logic [31:0]        timestamp_reg, timestamp_next;
    logic               ext_reg, ext_next;

    logic [CHUNK_W-1:0] eff_chunk;
    logic [23:0]        rem_dec;
    logic [CHUNK_W-1:0] chunk_inc;
    logic               begin_ext;
    logic [23:0]        ts_field;
    basic_t             bh_begin, bh_cont;
    logic [14:0][7:0]   tail_begin, tail_cont;
    logic [JOB_BYTES-1:0][7:0] cont_bytes;

    always_comb
    begin
        if (chunk_len_reg == '0)
            eff_chunk = 17'd1;
        else if (chunk_len_reg > MAX_CHUNK_BYTES)
            eff_chunk = MAX_CHUNK_BYTES;
        else
            eff_chunk = chunk_len_reg;

        begin_ext = msg_timestamp >= {8'd0, TS_CAP};
        ts_field  = begin_ext ? TS_CAP : msg_timestamp[23:0];
        bh_begin  = basic_hdr(FMT_FULL, stream_channel);
        bh_cont   = basic_hdr(FMT_CONT, channel_reg);

        tail_begin = '0;
        tail_begin[0]  = ts_field[23:16];
        tail_begin[1]  = ts_field[15:8];
        tail_begin[2]  = ts_field[7:0];
        tail_begin[3]  = msg_length[23:16];
        tail_begin[4]  = msg_length[15:8];
        tail_begin[5]  = msg_length[7:0];
        tail_begin[6]  = msg_type;
        tail_begin[7]  = msg_stream[7:0];
        tail_begin[8]  = msg_stream[15:8];
        tail_begin[9]  = msg_stream[23:16];
        tail_begin[10] = msg_stream[31:24];
        tail_begin[11] = msg_timestamp[31:24];
        tail_begin[12] = msg_timestamp[23:16];
        tail_begin[13] = msg_timestamp[15:8];
        tail_begin[14] = msg_timestamp[7:0];

        tail_cont = '0;
        tail_cont[0] = timestamp_reg[31:24];
        tail_cont[1] = timestamp_reg[23:16];
        tail_cont[2] = timestamp_reg[15:8];
        tail_cont[3] = timestamp_reg[7:0];
        cont_bytes = place(bh_cont, tail_cont);

        rem_dec   = remaining_reg - 24'd1;
        chunk_inc = in_chunk_reg + 17'd1;

        remaining_next = remaining_reg;
        in_chunk_next  = in_chunk_reg;
        channel_next   = channel_reg;
        timestamp_next = timestamp_reg;
        ext_next       = ext_reg;
        job            = '0;

        if (opcode == OP_BEGIN)
        begin
            channel_next   = stream_channel;
            timestamp_next = msg_timestamp;
            ext_next       = begin_ext;
            remaining_next = msg_length;
            in_chunk_next  = '0;
            job.data  = place(bh_begin, tail_begin);
            job.count = JOB_CNT_W'(bh_begin.len) + JOB_CNT_W'(11)
                        + (begin_ext ? JOB_CNT_W'(4) : JOB_CNT_W'(0));
            job.done  = msg_length == '0;
        end
        else if (remaining_reg != '0)
        begin
            remaining_next = rem_dec;
            in_chunk_next  = chunk_inc;
            job.data       = {cont_bytes[JOB_BYTES-2:0], payload_byte};
            if (rem_dec == '0)
            begin
                job.count = JOB_CNT_W'(1);
                job.done  = 1'b1;
            end
            else if (chunk_inc >= eff_chunk)
            begin
                // chunk boundary with data still to come: type 3 header
                in_chunk_next = '0;
                job.count = JOB_CNT_W'(1) + JOB_CNT_W'(bh_cont.len)
                            + (ext_reg ? JOB_CNT_W'(4) : JOB_CNT_W'(0));
            end
            else
            begin
                job.count = JOB_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_len_reg <= CHUNK_RESET;
            remaining_reg <= '0;
            in_chunk_reg  <= '0;
            channel_reg   <= '0;
            timestamp_reg <= '0;
            ext_reg       <= 1'b0;
        end
        else
        begin
            if (chunk_len_we)
                chunk_len_reg <= chunk_len;
            if (take)
            begin
                remaining_reg <= remaining_next;
                in_chunk_reg  <= in_chunk_next;
                channel_reg   <= channel_next;
                timestamp_reg <= timestamp_next;
                ext_reg       <= ext_next;
            end
        end
    end

endmodule

// ===== rtl/rcf_emit.sv =====
// Holds one transaction's byte list and shifts it out through the output register.
module rcf_emit
    import rcf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  job_t         job,
    output emit_status_t status,
    input  logic         out_ready,
    output logic         out_valid,
    output logic [7:0]   out_byte,
    output logic         run_last,
    output logic         message_done
);

    job_t                 job_reg;
    logic                 busy_reg;
    logic [JOB_CNT_W-1:0] idx_reg;
    logic                 out_valid_reg;
    logic [7:0]           out_byte_reg;
    logic                 run_last_reg;
    logic                 done_reg;
    logic                 last;
    logic                 advance;

    assign last    = idx_reg == (job_reg.count - JOB_CNT_W'(1));
    assign advance = busy_reg && (!out_valid_reg || out_ready);

    assign status.busy    = busy_reg;
    assign status.last    = last;
    assign status.advance = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                busy_reg <= job.count != '0;
                idx_reg  <= '0;
            end
            else if (advance)
            begin
                busy_reg <= !last;
                idx_reg  <= idx_reg + JOB_CNT_W'(1);
            end

            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            job_reg <= job;
        if (advance)
        begin
            out_byte_reg <= job_reg.data[idx_reg];
            run_last_reg <= last;
            done_reg     <= last && job_reg.done;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign run_last     = run_last_reg;
    assign message_done = done_reg;

endmodule

// ===== rtl/rtmp_chunk_framer.sv =====
// RTMP chunk framer top level: input handshake, builder and byte emitter.
// Each input transaction is built into its byte list combinationally, and the bytes leave
// one per cycle through a registered output while out_ready does not stall it. A payload
// byte that does not close a chunk gives a single byte, so payload streams at one byte
// per clock when not stalled. A begin transaction gives 12 to 18 bytes (basic header of
// 1-3 bytes, 11-byte message header, 4-byte extended timestamp when the timestamp is
// 0xFFFFFF or more), and a payload byte that closes a chunk with data left gives 2 to 8
// bytes; in_ready stays low until the last byte of the transaction is moving out.
// A payload byte with no message open is taken and produces nothing. chunk_len may be
// written at any cycle the block is idle and takes effect at once, 0 acting as 1.
module rtmp_chunk_framer
    import rcf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               chunk_len_we,
    input  logic [CHUNK_W-1:0] chunk_len,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               opcode,
    input  logic [16:0]        stream_channel,
    input  logic [31:0]        msg_timestamp,
    input  logic [23:0]        msg_length,
    input  logic [7:0]         msg_type,
    input  logic [31:0]        msg_stream,
    input  logic [7:0]         payload_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_byte,
    output logic               run_last,
    output logic               message_done
);

    job_t         job;
    emit_status_t status;
    logic         take;

    // new transaction may enter as the last pending byte moves to the output
    assign in_ready = !status.busy || (status.advance && status.last);
    assign take     = in_valid && in_ready;

    rcf_build u_build (
        .clk            (clk),
        .rst_n          (rst_n),
        .chunk_len_we   (chunk_len_we),
        .chunk_len      (chunk_len),
        .take           (take),
        .opcode         (opcode),
        .stream_channel (stream_channel),
        .msg_timestamp  (msg_timestamp),
        .msg_length     (msg_length),
        .msg_type       (msg_type),
        .msg_stream     (msg_stream),
        .payload_byte   (payload_byte),
        .job            (job)
    );

    rcf_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (take),
        .job          (job),
        .status       (status),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .out_byte     (out_byte),
        .run_last     (run_last),
        .message_done (message_done)
    );

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && message_done |-> run_last)
        else $error("message_done without run_last");

    a_begin_busy: assert property (@(posedge clk) disable iff (!rst_n)
        take && opcode == OP_BEGIN |=> status.busy)
        else $error("begin transaction produced no bytes");

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        status.busy && !status.last |-> !in_ready)
        else $error("input taken while several bytes still pending");

    a_emit_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        status.advance |=> out_valid)
        else $error("emitted byte missing from output register");

endmodule
